// ===== hw/rtl/srtf_pkg.sv =====
// Shared types and constants for the SRTF scheduler.
`default_nettype none
package srtf_pkg;

	localparam int MAX_JOBS_DEF  = 16;
	localparam int TIME_BITS_DEF = 16;
	localparam int FIELD_BITS    = 16;
	localparam int CLK_BITS      = 32;

	typedef enum logic [1:0] {
		KIND_ADD   = 2'd0,
		KIND_TICK  = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_RAN  = 2'd0,
		ST_IDLE = 2'd1,
		ST_FULL = 2'd2,
		ST_DONE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_CALC,
		S_DIFF,
		S_RESULT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;
		logic scan_issue;
		logic calc;
		logic diff;
		logic commit;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_tick;
		logic empty;
		logic last_issue;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/srtf_ctrl.sv =====
// Control state machine of the SRTF scheduler.
`default_nettype none
module srtf_ctrl
	import srtf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire dp_status_t st,
	output ctl_cmd_t        cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.latch = 1'b1;
					if (st.is_tick && !st.empty) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_RESULT;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (st.last_issue) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// last table entry is compared in this cycle
				state_d = S_CALC;
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_DIFF;
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = S_RESULT;
			end
			S_RESULT: begin
				if (st.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_scan_after_latch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch && st.is_tick && !st.empty |=> state_q == S_SCAN)
		else $error("tick with jobs did not start a scan");
	a_commit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> st.out_free)
		else $error("commit while output register busy");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_issue || cmd.calc || cmd.diff |-> in_stall)
		else $error("input open while a tick is in progress");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/srtf_dp.sv =====
// Datapath of the SRTF scheduler: job table, scan, timing math, result register.
`default_nettype none
module srtf_dp
	import srtf_pkg::*;
#(
	parameter int MAX_JOBS  = MAX_JOBS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF,
	localparam int IW = $clog2(MAX_JOBS),
	localparam int CW = $clog2(MAX_JOBS + 1),
	localparam int TW = TIME_BITS,
	localparam int EW = 3 * TW
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ctl_cmd_t              cmd,
	output dp_status_t                 st,
	input  wire logic [1:0]            kind,
	input  wire logic [FIELD_BITS-1:0] arrival_time,
	input  wire logic [FIELD_BITS-1:0] burst_time,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [1:0]                 status,
	output logic [CW-1:0]              job_id,
	output logic                       completed,
	output logic [CLK_BITS-1:0]        completion_time,
	output logic [CLK_BITS-1:0]        waiting_time,
	output logic [CLK_BITS-1:0]        turnaround_time
);

	// entry layout: {arrival, burst, remaining}
	logic [EW-1:0]       mem [MAX_JOBS];

	logic [1:0]          kind_q;
	logic [TW-1:0]       arr_in_q;
	logic [TW-1:0]       bur_in_q;
	logic [CW-1:0]       count_q;
	logic [CLK_BITS-1:0] now_q;

	logic [IW-1:0]       idx_q;
	logic                rd_valid_s1;
	logic [IW-1:0]       rd_idx_s1;
	logic [EW-1:0]       rd_entry_s1;

	logic                found_q;
	logic [IW-1:0]       best_idx_q;
	logic [TW-1:0]       best_arr_q;
	logic [TW-1:0]       best_bur_q;
	logic [TW-1:0]       best_rem_q;

	logic [CLK_BITS-1:0] comp_q;
	logic [CLK_BITS:0]   need_q;
	logic [CLK_BITS-1:0] wait_q;

	logic                out_valid_q;
	logic [1:0]          status_q;
	logic [CW-1:0]       job_id_q;
	logic                completed_q;
	logic [CLK_BITS-1:0] comp_out_q;
	logic [CLK_BITS-1:0] wait_out_q;
	logic [CLK_BITS-1:0] turn_out_q;

	logic [TW-1:0]       rd_arr, rd_bur, rd_rem;
	logic                elig, take;
	logic                full;
	logic [TW-1:0]       rem_dec;
	logic                fin;
	logic [CLK_BITS:0]   turn_sum;
	logic [CLK_BITS-1:0] turn_sat;
	logic                wr_en;
	logic [IW-1:0]       wr_addr;
	logic [EW-1:0]       wr_data;

	assign rd_arr = rd_entry_s1[EW-1 -: TW];
	assign rd_bur = rd_entry_s1[2*TW-1 -: TW];
	assign rd_rem = rd_entry_s1[TW-1:0];

	assign elig = (CLK_BITS'(rd_arr) <= now_q) && (rd_rem != '0);
	assign take = rd_valid_s1 && elig &&
		(!found_q || (rd_rem < best_rem_q) ||
		 ((rd_rem == best_rem_q) && (rd_arr < best_arr_q)));

	assign full     = (count_q == CW'(MAX_JOBS));
	assign rem_dec  = best_rem_q - TW'(1);
	assign fin      = (rem_dec == '0);
	assign turn_sum = {1'b0, wait_q} + (CLK_BITS + 1)'(best_bur_q);
	assign turn_sat = turn_sum[CLK_BITS] ? '1 : turn_sum[CLK_BITS-1:0];

	assign st.is_tick    = (kind == KIND_TICK);
	assign st.empty      = (count_q == '0);
	assign st.last_issue = (CW'(idx_q) == count_q - CW'(1));
	assign st.out_free   = !out_valid_q || !out_stall;

	// single write port: add stores a new job, tick writes back the decremented job
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = best_idx_q;
		wr_data = {best_arr_q, best_bur_q, rem_dec};
		if (cmd.commit) begin
			if (kind_q == KIND_ADD && !full) begin
				wr_en   = 1'b1;
				wr_addr = count_q[IW-1:0];
				wr_data = {arr_in_q, bur_in_q, bur_in_q};
			end else if (kind_q == KIND_TICK && found_q) begin
				wr_en = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.scan_issue) begin
			rd_entry_s1 <= mem[idx_q];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q   <= kind;
			arr_in_q <= TW'(CLK_BITS'(arrival_time));
			bur_in_q <= TW'(CLK_BITS'(burst_time));
		end
		if (cmd.scan_issue) begin
			rd_idx_s1 <= idx_q;
		end
		if (take) begin
			best_idx_q <= rd_idx_s1;
			best_arr_q <= rd_arr;
			best_bur_q <= rd_bur;
			best_rem_q <= rd_rem;
		end
		if (cmd.calc) begin
			comp_q <= (now_q == '1) ? now_q : now_q + CLK_BITS'(1);
			need_q <= (CLK_BITS + 1)'(best_arr_q) + (CLK_BITS + 1)'(best_bur_q);
		end
		if (cmd.diff) begin
			wait_q <= ({1'b0, comp_q} >= need_q) ?
				CLK_BITS'({1'b0, comp_q} - need_q) : '0;
		end
		if (cmd.commit) begin
			job_id_q    <= '0;
			completed_q <= 1'b0;
			comp_out_q  <= '0;
			wait_out_q  <= '0;
			turn_out_q  <= '0;
			case (kind_q)
				KIND_ADD: begin
					if (full) begin
						status_q <= ST_FULL;
					end else begin
						status_q <= ST_DONE;
						job_id_q <= count_q + CW'(1);
					end
				end
				KIND_TICK: begin
					if (found_q) begin
						status_q <= ST_RAN;
						job_id_q <= CW'(best_idx_q) + CW'(1);
						if (fin) begin
							completed_q <= 1'b1;
							comp_out_q  <= comp_q;
							wait_out_q  <= wait_q;
							turn_out_q  <= turn_sat;
						end
					end else begin
						status_q <= ST_IDLE;
					end
				end
				KIND_CLEAR: begin
					status_q <= ST_DONE;
				end
				default: begin
					status_q <= ST_IDLE;
				end
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			now_q       <= '0;
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.scan_issue;
			if (cmd.latch) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan_issue) begin
				idx_q <= idx_q + IW'(1);
			end
			if (take) begin
				found_q <= 1'b1;
			end
			if (cmd.commit) begin
				if (kind_q == KIND_ADD && !full) begin
					count_q <= count_q + CW'(1);
				end else if (kind_q == KIND_TICK && now_q != '1) begin
					now_q <= now_q + CLK_BITS'(1);
				end else if (kind_q == KIND_CLEAR) begin
					count_q <= '0;
					now_q   <= '0;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign job_id          = job_id_q;
	assign completed       = completed_q;
	assign completion_time = comp_out_q;
	assign waiting_time    = wait_out_q;
	assign turnaround_time = turn_out_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_JOBS))
		else $error("job count beyond table depth");
	a_read_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> CW'(rd_idx_s1) < count_q)
		else $error("scan read past loaded jobs");
	a_found_eligible: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && kind_q == KIND_TICK && found_q |->
			best_rem_q != '0 && CLK_BITS'(best_arr_q) <= now_q)
		else $error("chosen job not eligible");
	a_done_zero_times: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !completed_q |-> comp_out_q == '0 && turn_out_q == '0)
		else $error("time fields set without completion");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/srtf_scheduler.sv =====
// Top level of the shortest-remaining-time-first scheduler.
`default_nettype none
// Preemptive shortest-remaining-time-first scheduler. Each transaction on the
// input carries kind (add job, time tick, clear) and gives exactly one result.
// Add, clear and a tick on an empty table skip the scan and go from S_IDLE
// straight to S_RESULT. A tick scans the job table through its single
// registered read port, one entry per cycle over the loaded jobs, then steps
// through S_DRAIN, S_CALC and S_DIFF to S_RESULT. One transaction is
// processed at a time; the result register lets the next transaction in
// while a result waits.
// The job table holds TIME_BITS-bit arrival, burst and remaining times.
module srtf_scheduler
	import srtf_pkg::*;
#(
	parameter int MAX_JOBS  = MAX_JOBS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF,
	localparam int CW = $clog2(MAX_JOBS + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [1:0]            kind,
	input  wire logic [FIELD_BITS-1:0] arrival_time,
	input  wire logic [FIELD_BITS-1:0] burst_time,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [1:0]                 status,
	output logic [CW-1:0]              job_id,
	output logic                       completed,
	output logic [CLK_BITS-1:0]        completion_time,
	output logic [CLK_BITS-1:0]        waiting_time,
	output logic [CLK_BITS-1:0]        turnaround_time
);

	ctl_cmd_t   cmd;
	dp_status_t st;

	srtf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	srtf_dp #(
		.MAX_JOBS  (MAX_JOBS),
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.kind            (kind),
		.arrival_time    (arrival_time),
		.burst_time      (burst_time),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.job_id          (job_id),
		.completed       (completed),
		.completion_time (completion_time),
		.waiting_time    (waiting_time),
		.turnaround_time (turnaround_time)
	);

endmodule
`default_nettype wire

// ===== tb/srtf_checker.sv =====
// Checker for the SRTF scheduler: models the job table, predicts each result and compares it.
`timescale 1ns / 1ps
module srtf_checker
	import srtf_pkg::*;
#(
	parameter int ID_W = 5
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_stall,
	input  wire logic [1:0]            kind,
	input  wire logic [FIELD_BITS-1:0] arrival_time,
	input  wire logic [FIELD_BITS-1:0] burst_time,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  wire logic [1:0]            status,
	input  wire logic [ID_W-1:0]       job_id,
	input  wire logic                  completed,
	input  wire logic [CLK_BITS-1:0]   completion_time,
	input  wire logic [CLK_BITS-1:0]   waiting_time,
	input  wire logic [CLK_BITS-1:0]   turnaround_time,
	output int                         fail_count,
	output int                         outstanding,
	output int                         n_finished,
	output int                         n_idle,
	output int                         n_full
);

	typedef struct {
		logic [1:0]          status;
		logic [ID_W-1:0]     job_id;
		logic                completed;
		logic [CLK_BITS-1:0] comp;
		logic [CLK_BITS-1:0] wait_ticks;
		logic [CLK_BITS-1:0] turn;
	} sched_res_t;

	logic [TIME_BITS_DEF-1:0] job_arrival [MAX_JOBS_DEF];
	logic [TIME_BITS_DEF-1:0] job_burst   [MAX_JOBS_DEF];
	logic [TIME_BITS_DEF-1:0] job_left    [MAX_JOBS_DEF];
	logic [4:0]               njobs;
	logic [CLK_BITS-1:0]      clk_now;

	sched_res_t sched_res_q [$];
	sched_res_t want_r;
	sched_res_t pred_r;
	int         fails;
	int         finished_cnt;
	int         idle_cnt;
	int         full_cnt;

	task automatic check_field(input string what, input logic [CLK_BITS-1:0] want,
			input logic [CLK_BITS-1:0] got);
		if (want !== got) begin
			fails++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
		end
	endtask

	// Advance the scheduler model by one transaction and produce its result.
	task automatic schedule_step(input logic [1:0] k, input logic [FIELD_BITS-1:0] a,
			input logic [FIELD_BITS-1:0] b, output sched_res_t r);
		int                  best;
		bit                  found;
		logic [CLK_BITS-1:0] t0;
		logic [CLK_BITS-1:0] comp;
		logic [CLK_BITS-1:0] wt;
		logic [CLK_BITS:0]   need;
		logic [CLK_BITS:0]   turn;
		r.status     = ST_IDLE;
		r.job_id     = '0;
		r.completed  = 1'b0;
		r.comp       = '0;
		r.wait_ticks = '0;
		r.turn       = '0;
		best         = 0;
		found        = 0;
		case (k)
			KIND_ADD: begin
				if (njobs >= MAX_JOBS_DEF) begin
					r.status = ST_FULL;
				end else begin
					job_arrival[njobs] = a[TIME_BITS_DEF-1:0];
					job_burst[njobs]   = b[TIME_BITS_DEF-1:0];
					job_left[njobs]    = b[TIME_BITS_DEF-1:0];
					r.status = ST_DONE;
					r.job_id = ID_W'(njobs + 1);
					njobs++;
				end
			end
			KIND_TICK: begin
				for (int i = 0; i < njobs; i++) begin
					if (CLK_BITS'(job_arrival[i]) <= clk_now && job_left[i] != 0) begin
						// strict compare keeps the lower id on a full tie
						if (!found || job_left[i] < job_left[best] ||
								(job_left[i] == job_left[best] &&
								job_arrival[i] < job_arrival[best])) begin
							best  = i;
							found = 1;
						end
					end
				end
				t0 = clk_now;
				if (clk_now != '1)
					clk_now++;
				if (found) begin
					job_left[best]--;
					r.status = ST_RAN;
					r.job_id = ID_W'(best + 1);
					if (job_left[best] == 0) begin
						comp = (t0 == '1) ? '1 : t0 + 1;
						need = (CLK_BITS+1)'(job_burst[best]) + (CLK_BITS+1)'(job_arrival[best]);
						wt   = ({1'b0, comp} >= need) ? comp - need[CLK_BITS-1:0] : '0;
						turn = {1'b0, wt} + (CLK_BITS+1)'(job_burst[best]);
						if (turn[CLK_BITS])
							turn = {1'b0, {CLK_BITS{1'b1}}};
						r.completed  = 1'b1;
						r.comp       = comp;
						r.wait_ticks = wt;
						r.turn       = turn[CLK_BITS-1:0];
					end
				end
			end
			KIND_CLEAR: begin
				njobs    = '0;
				clk_now  = '0;
				r.status = ST_DONE;
			end
			default: r.status = ST_IDLE;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_JOBS_DEF; i++) begin
				job_arrival[i] = '0;
				job_burst[i]   = '0;
				job_left[i]    = '0;
			end
			njobs        = '0;
			clk_now      = '0;
			sched_res_q.delete();
			fails        = 0;
			finished_cnt = 0;
			idle_cnt     = 0;
			full_cnt     = 0;
			fail_count  <= 0;
			outstanding <= 0;
			n_finished  <= 0;
			n_idle      <= 0;
			n_full      <= 0;
		end else begin
			// a result always trails its own transaction, so pop before push
			if (out_valid && !out_stall) begin
				if (sched_res_q.size() == 0) begin
					fails++;
					$display("%0t: result with nothing expected: expected none, actual status %0d job_id %0d",
						$time, status, job_id);
				end else begin
					want_r = sched_res_q.pop_front();
					check_field("status", CLK_BITS'(want_r.status), CLK_BITS'(status));
					check_field("job_id", CLK_BITS'(want_r.job_id), CLK_BITS'(job_id));
					check_field("completed", CLK_BITS'(want_r.completed), CLK_BITS'(completed));
					check_field("completion_time", want_r.comp, completion_time);
					check_field("waiting_time", want_r.wait_ticks, waiting_time);
					check_field("turnaround_time", want_r.turn, turnaround_time);
				end
			end
			if (in_valid && !in_stall) begin
				schedule_step(kind, arrival_time, burst_time, pred_r);
				sched_res_q.insert(sched_res_q.size(), pred_r);
				if (pred_r.completed)
					finished_cnt++;
				if (kind == KIND_TICK && pred_r.status == ST_IDLE)
					idle_cnt++;
				if (pred_r.status == ST_FULL)
					full_cnt++;
			end
			fail_count  <= fails;
			outstanding <= sched_res_q.size();
			n_finished  <= finished_cnt;
			n_idle      <= idle_cnt;
			n_full      <= full_cnt;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Top of the SRTF scheduler testbench: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps
module tb_top;
	import srtf_pkg::*;

	localparam int         ID_W        = $clog2(MAX_JOBS_DEF + 1);
	localparam logic [1:0] KIND_SPARE  = 2'd3;
	localparam int         TOTAL_ITEMS = 1950;
	localparam int         QUIET_TAIL  = 150;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            kind;
	logic [FIELD_BITS-1:0] arrival_time;
	logic [FIELD_BITS-1:0] burst_time;
	logic                  out_valid;
	logic                  out_stall;
	logic [1:0]            status;
	logic [ID_W-1:0]       job_id;
	logic                  completed;
	logic [CLK_BITS-1:0]   completion_time;
	logic [CLK_BITS-1:0]   waiting_time;
	logic [CLK_BITS-1:0]   turnaround_time;

	int fail_count;
	int outstanding;
	int n_finished;
	int n_idle;
	int n_full;
	int sent;
	int gap_pct;
	bit quiet;

	srtf_scheduler u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.kind            (kind),
		.arrival_time    (arrival_time),
		.burst_time      (burst_time),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.job_id          (job_id),
		.completed       (completed),
		.completion_time (completion_time),
		.waiting_time    (waiting_time),
		.turnaround_time (turnaround_time)
	);

	srtf_checker #(.ID_W(ID_W)) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.kind            (kind),
		.arrival_time    (arrival_time),
		.burst_time      (burst_time),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.job_id          (job_id),
		.completed       (completed),
		.completion_time (completion_time),
		.waiting_time    (waiting_time),
		.turnaround_time (turnaround_time),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.n_finished      (n_finished),
		.n_idle          (n_idle),
		.n_full          (n_full)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end

	// Receiver back-pressure in random bursts.
	initial begin
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (!quiet && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	task automatic send_item(input logic [1:0] k, input logic [FIELD_BITS-1:0] a,
			input logic [FIELD_BITS-1:0] b);
		int n;
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			n = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid     <= 1'b1;
		kind         <= k;
		arrival_time <= a;
		burst_time   <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	// Hold the sender off until every transaction has produced its result.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Mostly small times so jobs arrive and finish; now and then any 16-bit value.
	function automatic logic [FIELD_BITS-1:0] pick_time(input int hi);
		if ($urandom_range(0, 15) == 0)
			return FIELD_BITS'($urandom());
		return FIELD_BITS'($urandom_range(0, hi));
	endfunction

	// One job set: optional clear, adds with ticks mixed in, then up to tick_cap ticks to finish them.
	task automatic run_job_set(input int n_jobs, input bit keep_time, input int tick_cap);
		int                    owed;
		int                    ticks;
		logic [FIELD_BITS-1:0] b;
		owed = 0;
		if (!keep_time)
			send_item(KIND_CLEAR, FIELD_BITS'($urandom()), FIELD_BITS'($urandom()));
		for (int j = 0; j < n_jobs; j++) begin
			b = pick_time(6);
			send_item(KIND_ADD, pick_time(20), b);
			if (b <= 6)
				owed += b;
			if ($urandom_range(0, 2) == 0)
				send_item(KIND_TICK, FIELD_BITS'($urandom()), FIELD_BITS'($urandom()));
		end
		ticks = owed + $urandom_range(0, 25);
		if (ticks > tick_cap)
			ticks = tick_cap;
		repeat (ticks)
			send_item(KIND_TICK, FIELD_BITS'($urandom()), FIELD_BITS'($urandom()));
	endtask

	initial begin
		int sel;
		in_valid     <= 1'b0;
		kind         <= KIND_TICK;
		arrival_time <= '0;
		burst_time   <= '0;
		arst_n       <= 1'b0;
		sent    = 0;
		gap_pct = 0;
		quiet   = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle tick, spare kind, ties, zero burst, extremes, full table
		send_item(KIND_TICK, 16'h0000, 16'h0000);
		send_item(KIND_SPARE, 16'hFFFF, 16'hFFFF);
		send_item(KIND_ADD, 16'd0, 16'd3);
		send_item(KIND_ADD, 16'd0, 16'd0);
		send_item(KIND_ADD, 16'd2, 16'd1);
		send_item(KIND_ADD, 16'hFFFF, 16'hFFFF);
		send_item(KIND_ADD, 16'd1, 16'd3);
		repeat (5)
			send_item(KIND_TICK, 16'h0000, 16'h0000);
		for (int j = 0; j < 11; j++)
			send_item(KIND_ADD, 16'd8, 16'd2);
		send_item(KIND_ADD, 16'd0, 16'd1);
		send_item(KIND_CLEAR, 16'h0000, 16'h0000);
		drain();

		while (sent < TOTAL_ITEMS) begin
			quiet = (sent >= TOTAL_ITEMS - QUIET_TAIL);
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 15;
				default: gap_pct = 50;
			endcase
			if (quiet)
				gap_pct = 0;
			sel = $urandom_range(0, 99);
			if (sel < 80) begin
				run_job_set(($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) :
					$urandom_range(1, 6), $urandom_range(0, 4) == 0, 200);
			end else if (sel < 90) begin
				repeat ($urandom_range(4, 12))
					send_item(2'($urandom()), FIELD_BITS'($urandom()),
						FIELD_BITS'($urandom()));
			end else begin
				// overfilled table cut short, left for the next set to clear or extend
				run_job_set($urandom_range(16, 20), $urandom_range(0, 1), $urandom_range(0, 6));
			end
			if ($urandom_range(0, 3) == 0)
				drain();
		end

		quiet = 1;
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Run: %0d transactions of all kinds, incl. random payloads and overfilled tables",
			sent);
		$display("Run: %0d jobs finished, %0d idle ticks, %0d table-full rejects",
			n_finished, n_idle, n_full);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
